/* src/scfc_pkg.sv */
// Package for the scope frame CRC-16 encoder.
// Holds the word types, frame constants and the byte-wise CRC-16/MODBUS update.
// No dependencies.
package scfc_pkg;

    localparam int unsigned FRAME_BYTES = 10;
    localparam int unsigned DATA_BYTES  = 8;
    localparam int unsigned IDX_W       = $clog2(FRAME_BYTES);
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam logic [IDX_W-1:0] IDX_CRC_LO = IDX_W'(DATA_BYTES);
    localparam logic [IDX_W-1:0] IDX_CRC_HI = IDX_W'(FRAME_BYTES - 1);

    typedef struct packed {
        logic signed [15:0] value_a;
        logic signed [15:0] value_b;
        logic signed [15:0] value_c;
        logic signed [15:0] value_d;
    } t_in_word;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic       frame_last;
    } t_out_word;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            if (crc[0]) begin
                crc = (crc >> 1) ^ CRC_POLY;
            end else begin
                crc = crc >> 1;
            end
        end
        return crc;
    endfunction

endpackage

/* src/scfc_front.sv */
// Front end of the scope frame encoder: accepts words and queues them.
// Two-entry queue toward the serializer. Depends on scfc_pkg.
module scfc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  scfc_pkg::t_in_word i_item,
    output logic              o_q_valid,
    output scfc_pkg::t_in_word o_q_item,
    input  logic              i_q_pop
);
    import scfc_pkg::*;

    t_in_word            r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr, n_wr;
    logic [QPTR_W-1:0]   r_rd, n_rd;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;
    logic                push;
    logic                pop;

    assign busy      = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign push      = start && !busy;
    assign o_q_valid = (r_cnt != '0);
    assign o_q_item  = r_mem[r_rd];
    assign pop       = i_q_pop && o_q_valid;

    always_comb begin
        n_wr  = push ? r_wr + 1'b1 : r_wr;
        n_rd  = pop ? r_rd + 1'b1 : r_rd;
        n_cnt = r_cnt + QCNT_W'(push) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

/* src/scfc_back.sv */
// Back end of the scope frame encoder: serializes one frame byte per cycle.
// Runs the CRC-16/MODBUS over the data bytes as they go out. Depends on scfc_pkg.
module scfc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  scfc_pkg::t_in_word i_q_item,
    output logic               o_q_pop,
    output logic               o_strobe,
    output scfc_pkg::t_out_word o_result
);
    import scfc_pkg::*;

    logic                      r_active;
    logic [IDX_W-1:0]          r_idx;
    logic [DATA_BYTES*8-1:0]   r_data;
    logic [15:0]               r_crc;
    logic                      r_strobe;
    t_out_word                 r_result;
    logic                      load;
    logic                      at_end;
    logic [7:0]                cur_byte;
    logic [15:0]               n_crc;

    assign at_end  = r_active && (r_idx == IDX_CRC_HI);
    assign load    = i_q_valid && (!r_active || at_end);
    assign o_q_pop = load;

    always_comb begin
        case (r_idx)
            IDX_CRC_LO: cur_byte = r_crc[7:0];
            IDX_CRC_HI: cur_byte = r_crc[15:8];
            default:    cur_byte = r_data[{r_idx[2:0], 3'b000} +: 8];
        endcase
        n_crc = (r_idx < IDX_CRC_LO) ? crc_byte(r_crc, cur_byte) : r_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_active;
            if (load) begin
                r_active <= 1'b1;
                r_idx    <= '0;
            end else if (at_end) begin
                r_active <= 1'b0;
            end else if (r_active) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.frame_byte <= cur_byte;
        r_result.frame_last <= at_end;
        if (load) begin
            r_data <= {i_q_item.value_d, i_q_item.value_c, i_q_item.value_b, i_q_item.value_a};
            r_crc  <= CRC_INIT;
        end else if (r_active) begin
            r_crc <= n_crc;
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

/* src/scope_frame_crc16_encoder_core.sv */
// Top level of the scope frame encoder: front queue plus byte serializer.
// Depends on scfc_pkg, scfc_front and scfc_back.
//
// Usage:
//   Drive i_item with four signed 16-bit channel values and raise start;
//   the word is taken at a rising edge where start is high and busy low.
//   Each word yields a 10-byte frame on o_result, one byte per cycle, each
//   marked by o_strobe for exactly one cycle: value_a low/high through
//   value_d low/high, then CRC-16/MODBUS low and high; frame_last marks
//   the CRC high byte.
//   When the serializer is idle, an accepted word passes the queue, the
//   serializer index register and the output register before its first byte.
//   Frames follow each other with no gap while the queue holds words; the
//   two-entry queue lets a new word be taken while a frame streams out.
//   busy rises only while the queue holds two words.
//   Reset (synchronous, active low) empties the queue and drops any frame
//   in flight. The receiver cannot stall; every strobe is a delivered byte.
module scope_frame_crc16_encoder_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  scfc_pkg::t_in_word  i_item,
    output logic                o_strobe,
    output scfc_pkg::t_out_word o_result
);
    import scfc_pkg::*;

    logic     q_valid;
    t_in_word q_item;
    logic     q_pop;

    scfc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_item    (i_item),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    scfc_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_strobe  (o_strobe),
        .o_result  (o_result)
    );

endmodule

/* dv/tb.sv */
`timescale 1ns / 1ps
// Testbench for scope_frame_crc16_encoder_core: checks every 10-byte frame
// against a CRC-16/MODBUS frame predictor over directed and random words.
// Depends on scfc_pkg and the encoder RTL.
module tb;
    import scfc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct {
        t_in_word word;
        bit       drain_first;
    } t_pending;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    logic      busy;
    t_in_word  i_item = '0;
    logic      o_strobe;
    t_out_word o_result;

    t_pending  pending[$];
    t_out_word frame_due[$];
    int        idle_pct = 0;
    int        error_count = 0;
    int        quiet_cycles = 0;

    scope_frame_crc16_encoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic logic [15:0] frame_crc16(input logic [7:0] data_bytes [DATA_BYTES]);
        logic [15:0] crc;
        crc = CRC_INIT;
        for (int k = 0; k < DATA_BYTES; k++) begin
            crc[7:0] = crc[7:0] ^ data_bytes[k];
            for (int b = 0; b < 8; b++) begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        return crc;
    endfunction

    task automatic predict_frame(input t_in_word w);
        logic [7:0]  data_bytes [DATA_BYTES];
        logic [15:0] crc;
        t_out_word   o;
        data_bytes[0] = w.value_a[7:0];
        data_bytes[1] = w.value_a[15:8];
        data_bytes[2] = w.value_b[7:0];
        data_bytes[3] = w.value_b[15:8];
        data_bytes[4] = w.value_c[7:0];
        data_bytes[5] = w.value_c[15:8];
        data_bytes[6] = w.value_d[7:0];
        data_bytes[7] = w.value_d[15:8];
        crc = frame_crc16(data_bytes);
        for (int k = 0; k < FRAME_BYTES; k++) begin
            if (k < DATA_BYTES) begin
                o.frame_byte = data_bytes[k];
            end else if (k == DATA_BYTES) begin
                o.frame_byte = crc[7:0];
            end else begin
                o.frame_byte = crc[15:8];
            end
            o.frame_last = (k == FRAME_BYTES - 1);
            frame_due.push_back(o);
        end
    endtask

    // driver: hold a word until taken, pause before a drain-first word
    always @(posedge i_clk) begin
        logic go;
        go = 1'b0;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                predict_frame(i_item);
                void'(pending.pop_front());
            end
            if (!(start && busy)) begin
                if (pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    go = 1'b1;
                    if (pending[0].drain_first && (frame_due.size() != 0 || o_strobe)) begin
                        go = 1'b0;
                    end
                end
                start <= go;
                if (go) begin
                    i_item <= pending[0].word;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_strobe) begin
            if (frame_due.size() == 0) begin
                $error("unexpected frame byte: frame_byte=%h frame_last=%b",
                       o_result.frame_byte, o_result.frame_last);
                error_count++;
            end else begin
                want = frame_due.pop_front();
                if (o_result.frame_byte !== want.frame_byte) begin
                    $error("frame_byte: expected %h, actual %h",
                           want.frame_byte, o_result.frame_byte);
                    error_count++;
                end
                if (o_result.frame_last !== want.frame_last) begin
                    $error("frame_last: expected %b, actual %b",
                           want.frame_last, o_result.frame_last);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_strobe) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic queue_word(input logic [15:0] a, input logic [15:0] b,
                              input logic [15:0] c, input logic [15:0] d,
                              input bit drain_first);
        t_pending p;
        p.word.value_a = a;
        p.word.value_b = b;
        p.word.value_c = c;
        p.word.value_d = d;
        p.drain_first  = drain_first;
        pending.push_back(p);
    endtask

    function automatic logic [15:0] channel_value();
        case ($urandom_range(9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            4: return 16'($urandom_range(255));
            5: return 16'(-$urandom_range(256));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_phase(input int count, input int pct);
        idle_pct = pct;
        for (int n = 0; n < count; n++) begin
            queue_word(channel_value(), channel_value(), channel_value(), channel_value(),
                       n == 0 || $urandom_range(19) == 0);
        end
        while (pending.size() != 0) @(negedge i_clk);
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        idle_pct = 0;
        queue_word(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        queue_word(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        queue_word(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
        queue_word(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b0);
        queue_word(16'h8000, 16'h7FFF, 16'hFFFF, 16'h0001, 1'b0);
        queue_word(16'h0001, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        queue_word(16'h0000, 16'h0000, 16'h0000, 16'h8000, 1'b0);
        queue_word(16'h00FF, 16'hFF00, 16'h00FF, 16'hFF00, 1'b0);
        queue_word(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1'b0);
        queue_word(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1);
        queue_word(16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 1'b0);
        queue_word(16'hFFFE, 16'h0002, 16'hFF80, 16'h007F, 1'b0);
        queue_word(16'h0100, 16'h0080, 16'hC000, 16'h4000, 1'b1);
        while (pending.size() != 0) @(negedge i_clk);
        run_phase(60, 0);
        run_phase(60, 87);
        run_phase(50, 24);
        run_phase(50, 0);
        while (pending.size() != 0 || frame_due.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (error_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

/* sim.f */
src/scfc_pkg.sv
src/scfc_front.sv
src/scfc_back.sv
src/scope_frame_crc16_encoder_core.sv
dv/tb.sv
